>>> rtl/neural_activation_unit_top_assert.svh
// Assertion macros used by the activation unit top level.
`ifndef NEURAL_ACTIVATION_UNIT_TOP_ASSERT_SVH
`define NEURAL_ACTIVATION_UNIT_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked on every rising edge outside reset.
`define NAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define NAU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NAU_ASSERT(lbl, prop, msg)
`define NAU_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> rtl/nau_pkg.sv
// Shared constants, codes and types of the activation unit.
package nau_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 12;
  localparam int Q_BITS     = 30;
  localparam int SH         = Q_BITS - FRAC_BITS;

  localparam logic [63:0] LN2_Q30 = 64'd744261118;

  // Exponential series unit.
  localparam int T_W       = DATA_WIDTH + SH + 1;
  localparam int E_W       = Q_BITS + 1;
  localparam int R_W       = Q_BITS;
  localparam int EXP_TERMS = 13;
  localparam int EXP_KMAX  = 23;
  localparam int K_W       = 5;
  localparam int EXP_LAT   = 2 * EXP_TERMS + 3;

  // Restoring divider, used by the top level and by each log unit.
  localparam int QUO_W   = Q_BITS + 1;
  localparam int DEN_W   = Q_BITS + 2;
  localparam int NUM_W   = 2 * Q_BITS + 1;
  localparam int DIV_LAT = QUO_W;

  // Natural log unit.
  localparam int U_W      = FRAC_BITS + 2;
  localparam int EU_W     = 4;
  localparam int LN_TERMS = 13;
  localparam int LN_W     = Q_BITS + 5;
  localparam int LN_LAT   = DIV_LAT + LN_TERMS + 3;

  // Top level timing.
  localparam int SIDE_LAST = EXP_LAT + DIV_LAT;
  localparam int LN_PAD    = SIDE_LAST - LN_LAT;
  localparam int OUT_LAT   = SIDE_LAST + 3;
  localparam int MAG_W     = LN_W + 1 - SH;

  typedef enum logic [2:0] {
    FS_TANH    = 3'd0,
    FS_RELU    = 3'd1,
    FS_SIGMOID = 3'd2,
    FS_LINEAR  = 3'd3,
    FS_RETANH  = 3'd4
  } fsel_t;

  typedef enum logic [1:0] {
    KIND_ACT   = 2'd0,
    KIND_DERIV = 2'd1,
    KIND_INV   = 2'd2,
    KIND_BAD   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    SRC_DIRECT = 3'd0,
    SRC_TANH   = 3'd1,
    SRC_SIG    = 3'd2,
    SRC_ATANH  = 3'd3,
    SRC_LOGIT  = 3'd4
  } src_t;

  typedef enum logic [1:0] {
    DM_VALUE  = 2'd0,
    DM_ONE_SQ = 2'd1,
    DM_MUL    = 2'd2
  } dmode_t;

  typedef struct packed {
    src_t                          src;
    logic signed [DATA_WIDTH-1:0]  v;
    logic signed [DATA_WIDTH-1:0]  dres;
    logic                          derr;
  } side_t;

endpackage

>>> rtl/neural_activation_unit_top.sv
// Top level of the element-wise activation unit in signed Q3.12.
//
//  channel     | signals                          | timing
//  ------------+----------------------------------+----------------------------
//  item in     | start, busy, kind, operand_value | taken when start && !busy
//  result out  | done, result_value, domain_error | one cycle, cannot be held
//  config      | cfg_wr_en, cfg_wr_data           | written on cfg_wr_en
//
// One item can be taken on every clock outside reset. The latency is set by the
// e^-x series (29 stages) followed by the 31-stage restoring divider for
// tanh and sigmoid. The log path (47 stages) is padded to the same length.
// Reset is synchronous; it clears all valid bits and the function select, and
// busy is high while reset is asserted. Since the receiver cannot stall,
// the pipeline never stops and busy is otherwise low.
`include "neural_activation_unit_top_assert.svh"

module neural_activation_unit_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic signed [15:0] operand_value,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  output logic        done,
  output logic signed [15:0] result_value,
  output logic        domain_error
);

  localparam int DW   = nau_pkg::DATA_WIDTH;
  localparam int SH   = nau_pkg::SH;
  localparam int QB   = nau_pkg::Q_BITS;
  localparam int LAST = nau_pkg::SIDE_LAST;
  localparam int XL   = nau_pkg::EXP_LAT;
  localparam int MW   = nau_pkg::MAG_W;
  localparam int DLW  = nau_pkg::LN_W + 1;
  localparam logic signed [DW-1:0]   ONE_FX = DW'(1) << nau_pkg::FRAC_BITS;
  localparam logic signed [DW-1:0]   MAX_FX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0]   MIN_FX = {1'b1, {(DW-1){1'b0}}};

  // Function select register.
  logic [2:0] fsel_cfg;

  // Input stage.
  logic                  a_vld;
  nau_pkg::kind_t        a_kind;
  logic signed [DW-1:0]  a_v;
  nau_pkg::fsel_t        a_sel;
  nau_pkg::fsel_t        sel_map;
  logic                  accept;

  // Shared operand forms.
  logic signed [DW:0]    a_v17;
  logic signed [DW:0]    a_neg17;
  logic [DW-1:0]         a_mag;
  logic signed [DW:0]    a_om;
  logic [DW-1:0]         a_om_mag;
  logic                  tanh_like;
  logic                  gate_zero;

  // Unit operands.
  logic [nau_pkg::T_W-1:0]   exp_t;
  logic [nau_pkg::E_W-1:0]   exp_e;
  logic [nau_pkg::U_W-1:0]   ln_ua;
  logic [nau_pkg::U_W-1:0]   ln_ub;
  logic [nau_pkg::LN_W-1:0]  ln_a;
  logic [nau_pkg::LN_W-1:0]  ln_b;
  logic [nau_pkg::NUM_W-1:0] div_num;
  logic [nau_pkg::DEN_W-1:0] div_den;
  logic [nau_pkg::QUO_W-1:0] div_quo;

  // Stage 1 decode.
  nau_pkg::src_t         dec_src;
  nau_pkg::dmode_t       dec_dm;
  logic signed [DW-1:0]  dec_val;
  logic                  dec_err;
  nau_pkg::src_t         s1_src;
  nau_pkg::dmode_t       s1_dm;
  logic signed [DW-1:0]  s1_val;
  logic                  s1_err;
  logic [2*DW-1:0]       s1_prod;
  logic                  s1_pneg;
  logic signed [DW-1:0]  s1_v;

  // Stage 2 direct result.
  logic [2*DW+1:0]       rr_sum;
  logic [DW+3:0]         rr;
  logic signed [DW+4:0]  one_sq;
  nau_pkg::side_t        s2_next;

  nau_pkg::side_t        side_q [2:LAST];
  logic [LAST:1]         vld_q;

  // Log difference padding.
  logic signed [DLW-1:0] d_q [0:nau_pkg::LN_PAD-1];
  logic signed [DLW-1:0] d_end;
  logic [DLW-1:0]        d_abs;

  // Final rounding and saturation.
  logic                  f1_vld;
  logic                  f1_direct;
  logic signed [DW-1:0]  f1_dres;
  logic                  f1_derr;
  logic [MW-1:0]         f1_mag;
  logic                  f1_neg;
  logic [MW-1:0]         mag_next;
  logic                  neg_next;
  logic [MW-1:0]         neg_mag;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      fsel_cfg <= nau_pkg::FS_TANH;
    end else if (cfg_wr_en) begin
      fsel_cfg <= cfg_wr_data;
    end
  end

  // Unused select codes behave as linear.
  always_comb begin
    case (fsel_cfg)
      nau_pkg::FS_TANH:    sel_map = nau_pkg::FS_TANH;
      nau_pkg::FS_RELU:    sel_map = nau_pkg::FS_RELU;
      nau_pkg::FS_SIGMOID: sel_map = nau_pkg::FS_SIGMOID;
      nau_pkg::FS_RETANH:  sel_map = nau_pkg::FS_RETANH;
      default:             sel_map = nau_pkg::FS_LINEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= accept;
    end
    a_kind <= nau_pkg::kind_t'(kind);
    a_v    <= operand_value;
    a_sel  <= sel_map;
  end

  assign a_v17     = DW'(a_v) == '0 ? '0 : {a_v[DW-1], a_v};
  assign a_neg17   = -a_v17;
  assign a_mag     = a_v[DW-1] ? a_neg17[DW-1:0] : a_v;
  assign a_om      = {ONE_FX[DW-1], ONE_FX} - a_v17;
  assign a_om_mag  = a_om[DW] ? DW'(-a_om) : a_om[DW-1:0];
  assign tanh_like = (a_sel == nau_pkg::FS_TANH) || (a_sel == nau_pkg::FS_RETANH);
  assign gate_zero = (a_sel == nau_pkg::FS_RETANH) && (a_v <= 0);

  // Tanh evaluates e^-2|x|, sigmoid e^-|x|.
  assign exp_t = (a_sel == nau_pkg::FS_SIGMOID) ? nau_pkg::T_W'(a_mag) << SH
                                                 : nau_pkg::T_W'(a_mag) << (SH + 1);

  // Log arguments; out-of-domain items get a harmless argument of one.
  always_comb begin
    ln_ua = nau_pkg::U_W'(1);
    ln_ub = nau_pkg::U_W'(1);
    if (tanh_like && (a_v > -ONE_FX) && (a_v < ONE_FX)) begin
      ln_ua = nau_pkg::U_W'(a_v17 + {ONE_FX[DW-1], ONE_FX});
      ln_ub = nau_pkg::U_W'(a_om);
    end else if ((a_sel == nau_pkg::FS_SIGMOID) && (a_v > 0) && (a_v < ONE_FX)) begin
      ln_ua = nau_pkg::U_W'(a_v);
      ln_ub = nau_pkg::U_W'(a_om);
    end
  end

  nau_exp u_exp (
    .clk (clk),
    .t   (exp_t),
    .e   (exp_e)
  );

  nau_ln u_ln_a (
    .clk (clk),
    .u   (ln_ua),
    .lnv (ln_a)
  );

  nau_ln u_ln_b (
    .clk (clk),
    .u   (ln_ub),
    .lnv (ln_b)
  );

  // Decode of what each item needs.
  always_comb begin
    dec_src = nau_pkg::SRC_DIRECT;
    dec_dm  = nau_pkg::DM_VALUE;
    dec_val = '0;
    dec_err = 1'b0;
    case (a_kind)
      nau_pkg::KIND_ACT: begin
        case (a_sel) inside
          nau_pkg::FS_TANH, nau_pkg::FS_RETANH: begin
            if (!gate_zero) begin
              dec_src = nau_pkg::SRC_TANH;
            end
          end
          nau_pkg::FS_RELU:    dec_val = (a_v > 0) ? a_v : '0;
          nau_pkg::FS_SIGMOID: dec_src = nau_pkg::SRC_SIG;
          default:             dec_val = a_v;
        endcase
      end
      nau_pkg::KIND_DERIV: begin
        case (a_sel) inside
          nau_pkg::FS_TANH, nau_pkg::FS_RETANH: begin
            if (!gate_zero) begin
              dec_dm = nau_pkg::DM_ONE_SQ;
            end
          end
          nau_pkg::FS_RELU:    dec_val = (a_v > 0) ? ONE_FX : '0;
          nau_pkg::FS_SIGMOID: dec_dm = nau_pkg::DM_MUL;
          default:             dec_val = ONE_FX;
        endcase
      end
      nau_pkg::KIND_INV: begin
        case (a_sel) inside
          nau_pkg::FS_TANH, nau_pkg::FS_RETANH: begin
            if (a_v >= ONE_FX) begin
              dec_val = MAX_FX;
              dec_err = 1'b1;
            end else if (a_v <= -ONE_FX) begin
              dec_val = MIN_FX;
              dec_err = 1'b1;
            end else begin
              dec_src = nau_pkg::SRC_ATANH;
            end
          end
          nau_pkg::FS_SIGMOID: begin
            if (a_v <= 0) begin
              dec_val = MIN_FX;
              dec_err = 1'b1;
            end else if (a_v >= ONE_FX) begin
              dec_val = MAX_FX;
              dec_err = 1'b1;
            end else begin
              dec_src = nau_pkg::SRC_LOGIT;
            end
          end
          default: dec_val = a_v;
        endcase
      end
      default: begin
        dec_val = '0;
        dec_err = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    s1_src  <= dec_src;
    s1_dm   <= dec_dm;
    s1_val  <= dec_val;
    s1_err  <= dec_err;
    s1_prod <= (2*DW)'(a_mag) * (2*DW)'(tanh_like ? a_mag : a_om_mag);
    s1_pneg <= (a_sel == nau_pkg::FS_SIGMOID) && (a_v[DW-1] != a_om[DW]);
    s1_v    <= a_v;
  end

  // Derivative products, rounded half away from zero and saturated.
  assign rr_sum = (2*DW+2)'(s1_prod) + (2*DW+2)'(1 << (nau_pkg::FRAC_BITS - 1));
  assign rr     = (DW+4)'(rr_sum >> nau_pkg::FRAC_BITS);
  assign one_sq = (DW+5)'(ONE_FX) - $signed({1'b0, rr});

  always_comb begin
    s2_next.src  = s1_src;
    s2_next.v    = s1_v;
    s2_next.dres = s1_val;
    s2_next.derr = s1_err;
    case (s1_dm)
      nau_pkg::DM_ONE_SQ: begin
        if (one_sq < $signed((DW+5)'(MIN_FX))) begin
          s2_next.dres = MIN_FX;
          s2_next.derr = 1'b1;
        end else begin
          s2_next.dres = one_sq[DW-1:0];
        end
      end
      nau_pkg::DM_MUL: begin
        if (s1_pneg) begin
          if (rr > (DW+4)'(1 << (DW - 1))) begin
            s2_next.dres = MIN_FX;
            s2_next.derr = 1'b1;
          end else begin
            s2_next.dres = DW'(-rr);
          end
        end else begin
          if (rr > (DW+4)'(MAX_FX)) begin
            s2_next.dres = MAX_FX;
            s2_next.derr = 1'b1;
          end else begin
            s2_next.dres = rr[DW-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    side_q[2] <= s2_next;
    for (int i = 3; i <= LAST; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAST-1:1], a_vld};
    end
  end

  // Tanh: (1 - e) / (1 + e). Sigmoid: 1 / (1 + e) or e / (1 + e) for x < 0.
  always_comb begin
    div_den = nau_pkg::DEN_W'(exp_e) + (nau_pkg::DEN_W'(1) << QB);
    if (side_q[XL].src == nau_pkg::SRC_TANH) begin
      div_num = {(nau_pkg::E_W'(1) << QB) - exp_e, {QB{1'b0}}};
    end else if (side_q[XL].v < 0) begin
      div_num = {exp_e, {QB{1'b0}}};
    end else begin
      div_num = nau_pkg::NUM_W'(1) << (2 * QB);
    end
  end

  nau_div u_div (
    .clk (clk),
    .num (div_num),
    .den (div_den),
    .quo (div_quo)
  );

  always_ff @(posedge clk) begin
    d_q[0] <= $signed({1'b0, ln_a}) - $signed({1'b0, ln_b});
    for (int i = 1; i < nau_pkg::LN_PAD; i++) begin
      d_q[i] <= d_q[i-1];
    end
  end

  assign d_end = d_q[nau_pkg::LN_PAD-1];
  assign d_abs = d_end[DLW-1] ? DLW'(-d_end) : DLW'(d_end);

  always_comb begin
    mag_next = '0;
    neg_next = 1'b0;
    case (side_q[LAST].src)
      nau_pkg::SRC_TANH: begin
        mag_next = MW'((DLW'(div_quo) + DLW'(1 << (SH - 1))) >> SH);
        neg_next = side_q[LAST].v < 0;
      end
      nau_pkg::SRC_SIG: begin
        mag_next = MW'((DLW'(div_quo) + DLW'(1 << (SH - 1))) >> SH);
      end
      nau_pkg::SRC_ATANH: begin
        mag_next = MW'((d_abs + DLW'(1 << SH)) >> (SH + 1));
        neg_next = d_end[DLW-1];
      end
      nau_pkg::SRC_LOGIT: begin
        mag_next = MW'((d_abs + DLW'(1 << (SH - 1))) >> SH);
        neg_next = d_end[DLW-1];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
    end else begin
      f1_vld <= vld_q[LAST];
    end
    f1_direct <= side_q[LAST].src == nau_pkg::SRC_DIRECT;
    f1_dres   <= side_q[LAST].dres;
    f1_derr   <= side_q[LAST].derr;
    f1_mag    <= mag_next;
    f1_neg    <= neg_next;
  end

  assign neg_mag = -f1_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f1_vld;
    end
    if (f1_direct) begin
      result_value <= f1_dres;
      domain_error <= f1_derr;
    end else if (f1_neg) begin
      if (f1_mag > MW'(1 << (DW - 1))) begin
        result_value <= MIN_FX;
        domain_error <= 1'b1;
      end else begin
        result_value <= neg_mag[DW-1:0];
        domain_error <= 1'b0;
      end
    end else begin
      if (f1_mag > MW'(MAX_FX)) begin
        result_value <= MAX_FX;
        domain_error <= 1'b1;
      end else begin
        result_value <= f1_mag[DW-1:0];
        domain_error <= 1'b0;
      end
    end
  end

  // Every accepted item comes out after the fixed latency.
  `NAU_ASSERT(a_item_done, (start && !busy) |-> ##(nau_pkg::OUT_LAT) done, "item lost")
  // A result strobe always traces back to a valid item at the last side stage.
  `NAU_ASSERT(a_done_src, done |-> $past(vld_q[LAST], 2), "result without item")
  // An unused kind yields zero with the error flag.
  `NAU_ASSERT(a_bad_kind, (start && !busy && kind == nau_pkg::KIND_BAD) |->
    ##(nau_pkg::OUT_LAT) (done && domain_error && result_value == 0), "bad kind")
  // Reset empties the output stage.
  `NAU_ASSERT_RST(a_rst_done, rst |=> !done, "done after reset")

endmodule

>>> rtl/nau_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module nau_div (
  input  logic                       clk,
  input  logic [nau_pkg::NUM_W-1:0]  num,
  input  logic [nau_pkg::DEN_W-1:0]  den,
  output logic [nau_pkg::QUO_W-1:0]  quo
);

  localparam int NW    = nau_pkg::NUM_W;
  localparam int DW    = nau_pkg::DEN_W;
  localparam int QW    = nau_pkg::QUO_W;
  localparam int CMP_W = DW + QW - 1;

  logic [NW-1:0] rem_q [0:QW-1];
  logic [DW-1:0] den_q [0:QW-1];
  logic [QW-1:0] quo_q [0:QW-1];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int Bit = QW - 1 - j;
    logic [NW-1:0]    rem_in;
    logic [DW-1:0]    den_in;
    logic [QW-1:0]    quo_in;
    logic [CMP_W-1:0] dsh;
    logic [CMP_W-1:0] rem_ext;
    logic [CMP_W-1:0] diff;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    assign dsh     = CMP_W'(den_in) << Bit;
    assign rem_ext = CMP_W'(rem_in);
    assign diff    = rem_ext - dsh;

    always_ff @(posedge clk) begin
      den_q[j] <= den_in;
      if (rem_ext >= dsh) begin
        rem_q[j] <= diff[NW-1:0];
        quo_q[j] <= quo_in | (QW'(1) << Bit);
      end else begin
        rem_q[j] <= rem_in;
        quo_q[j] <= quo_in;
      end
    end
  end

  assign quo = quo_q[QW-1];

endmodule

>>> rtl/nau_exp.sv
// Pipelined e^-t in Q30: range reduction by ln 2, then a Taylor series.
module nau_exp (
  input  logic                     clk,
  input  logic [nau_pkg::T_W-1:0]  t,
  output logic [nau_pkg::E_W-1:0]  e
);

  localparam int N      = nau_pkg::EXP_TERMS;
  localparam int EW     = nau_pkg::E_W;
  localparam int RW     = nau_pkg::R_W;
  localparam int KW     = nau_pkg::K_W;
  localparam int SUM_W  = EW + 2;
  localparam int PROD_W = EW + RW;
  localparam int QP_W   = 2 * RW + 1;
  localparam logic [EW-1:0]           TERM_ONE = EW'(1) << nau_pkg::Q_BITS;
  localparam logic signed [SUM_W-1:0] SUM_ONE  = SUM_W'(1) << nau_pkg::Q_BITS;

  logic [nau_pkg::T_W-1:0] t1;
  logic [KW-1:0]           k1;
  logic [KW-1:0]           k_cnt;
  logic [63:0]             r_full;

  logic [RW-1:0]            r_q    [0:2*N];
  logic [KW-1:0]            k_q    [0:2*N];
  logic signed [SUM_W-1:0]  sum_q  [0:2*N];
  logic [EW-1:0]            term_q [0:N];
  logic [PROD_W-1:0]        prod_q [1:N];

  // Number of whole ln 2 steps in t; the compares are monotonic in j.
  always_comb begin
    k_cnt = '0;
    for (int j = 1; j <= nau_pkg::EXP_KMAX; j++) begin
      if (64'(t) >= 64'(j) * nau_pkg::LN2_Q30) begin
        k_cnt = KW'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    t1 <= t;
    k1 <= k_cnt;
  end

  assign r_full = 64'(t1) - 64'(k1) * nau_pkg::LN2_Q30;

  always_ff @(posedge clk) begin
    r_q[0]    <= r_full[RW-1:0];
    k_q[0]    <= k1;
    term_q[0] <= TERM_ONE;
    sum_q[0]  <= SUM_ONE;
  end

  for (genvar n = 1; n <= N; n++) begin : g_term
    localparam int Div = n;
    // The scaled product stays below 2^30, so multiplying by
    // ceil(2^Sft / Div) and shifting gives the exact floor quotient.
    localparam int Sft = nau_pkg::Q_BITS + $clog2(Div);
    localparam longint unsigned Recip =
      ((64'd1 << Sft) + 64'(Div) - 64'd1) / 64'(Div);
    logic [RW-1:0]           quot_in;
    logic [QP_W-1:0]         qprod;
    logic [EW-1:0]           tdiv;
    logic signed [SUM_W-1:0] tsgn;

    always_ff @(posedge clk) begin
      prod_q[n]    <= PROD_W'(term_q[n-1]) * PROD_W'(r_q[2*n-2]);
      r_q[2*n-1]   <= r_q[2*n-2];
      k_q[2*n-1]   <= k_q[2*n-2];
      sum_q[2*n-1] <= sum_q[2*n-2];
    end

    assign quot_in = prod_q[n][nau_pkg::Q_BITS +: RW];
    assign qprod   = QP_W'(quot_in) * QP_W'(Recip);
    assign tdiv    = EW'(qprod >> Sft);
    // Odd powers of -r subtract, even powers add.
    assign tsgn = (Div % 2 == 1) ? -$signed(SUM_W'(tdiv)) : $signed(SUM_W'(tdiv));

    always_ff @(posedge clk) begin
      term_q[n]  <= tdiv;
      r_q[2*n]   <= r_q[2*n-1];
      k_q[2*n]   <= k_q[2*n-1];
      sum_q[2*n] <= sum_q[2*n-1] + tsgn;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_q[2*N] < 0) begin
      e <= '0;
    end else begin
      e <= sum_q[2*N][EW-1:0] >> k_q[2*N];
    end
  end

endmodule

>>> rtl/nau_ln.sv
// Pipelined natural log of a small positive integer, result in Q30.
module nau_ln (
  input  logic                      clk,
  input  logic [nau_pkg::U_W-1:0]   u,
  output logic [nau_pkg::LN_W-1:0]  lnv
);

  localparam int N     = nau_pkg::LN_TERMS;
  localparam int QB    = nau_pkg::Q_BITS;
  localparam int RW    = nau_pkg::R_W;
  localparam int EUW   = nau_pkg::EU_W;
  localparam int M_W   = QB + 1;
  localparam int SUM_W = QB + 1;
  localparam int PW_W  = 2 * RW;
  localparam int QP_W  = 2 * RW + 1;
  localparam int DL    = nau_pkg::DIV_LAT;
  localparam logic [M_W-1:0] M_ONE = M_W'(1) << QB;

  logic [EUW-1:0]              e_cnt;
  logic [EUW-1:0]              e1;
  logic [M_W-1:0]              m1;
  logic [nau_pkg::NUM_W-1:0]   num;
  logic [nau_pkg::DEN_W-1:0]   den;
  logic [nau_pkg::QUO_W-1:0]   quo;
  logic [EUW-1:0]              e_d   [0:DL-1];
  logic [RW-1:0]               pw_q  [0:N];
  logic [RW-1:0]               s2_q  [0:N];
  logic [SUM_W-1:0]            sum_q [0:N];
  logic [EUW-1:0]              e_q   [0:N];
  logic [PW_W-1:0]             s_sq;

  // Leading one position of u.
  always_comb begin
    e_cnt = '0;
    for (int b = 0; b < nau_pkg::U_W; b++) begin
      if (u[b]) begin
        e_cnt = EUW'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    e1 <= e_cnt;
    m1 <= M_W'(u) << (QB - int'(e_cnt));
  end

  // s = (m - 1) / (m + 1) with m normalized to [1, 2).
  assign num = {m1 - M_ONE, {QB{1'b0}}};
  assign den = nau_pkg::DEN_W'(m1) + nau_pkg::DEN_W'(M_ONE);

  nau_div u_div (
    .clk (clk),
    .num (num),
    .den (den),
    .quo (quo)
  );

  always_ff @(posedge clk) begin
    e_d[0] <= e1;
    for (int i = 1; i < DL; i++) begin
      e_d[i] <= e_d[i-1];
    end
  end

  assign s_sq = PW_W'(quo[RW-1:0]) * PW_W'(quo[RW-1:0]);

  always_ff @(posedge clk) begin
    pw_q[0]  <= quo[RW-1:0];
    s2_q[0]  <= RW'(s_sq >> QB);
    sum_q[0] <= '0;
    e_q[0]   <= e_d[DL-1];
  end

  // Series for atanh(s): sum of s^k / k over odd k.
  for (genvar j = 0; j < N; j++) begin : g_term
    localparam int Div = 2 * j + 1;
    // Powers of s stay below 2^30, so a reciprocal multiply by
    // ceil(2^Sft / Div) followed by a shift is an exact floor quotient.
    localparam int Sft = QB + $clog2(Div);
    localparam longint unsigned Recip =
      ((64'd1 << Sft) + 64'(Div) - 64'd1) / 64'(Div);
    logic [PW_W-1:0] pprod;
    logic [QP_W-1:0] qprod;

    assign pprod = PW_W'(pw_q[j]) * PW_W'(s2_q[j]);
    assign qprod = QP_W'(pw_q[j]) * QP_W'(Recip);

    always_ff @(posedge clk) begin
      sum_q[j+1] <= sum_q[j] + SUM_W'(qprod >> Sft);
      pw_q[j+1]  <= RW'(pprod >> QB);
      s2_q[j+1]  <= s2_q[j];
      e_q[j+1]   <= e_q[j];
    end
  end

  always_ff @(posedge clk) begin
    lnv <= nau_pkg::LN_W'(e_q[N]) * nau_pkg::LN_W'(nau_pkg::LN2_Q30)
         + (nau_pkg::LN_W'(sum_q[N]) << 1);
  end

endmodule

>>> bench/tb_neural_activation_unit_top.sv
// Self-checking testbench for the element-wise activation unit top level.
module tb_neural_activation_unit_top;

  timeunit 1ns;
  timeprecision 1ps;

  // Select codes 5 to 7 are unused and must behave as linear.
  localparam logic [2:0] FS_SPARE_LO = 3'd5;
  localparam logic [2:0] FS_SPARE_HI = 3'd7;
  localparam int         N_RANDOM    = 1330;
  localparam int         CYCLE_LIMIT = 200000;
  // The tail wait covers the pipeline depth with margin.
  localparam int         TAIL_CYCLES = 80;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned LN2_Q   = 64'd744261118;
  localparam logic signed [15:0] POS_MAX = 16'sh7fff;
  localparam logic signed [15:0] NEG_MAX = -16'sh8000;
  localparam logic signed [15:0] ONE_FX  = 16'sd4096;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [1:0]               kind;
  logic signed [15:0]       operand_value;
  logic                     cfg_wr_en;
  logic [2:0]               cfg_wr_data;
  logic                     done;
  logic signed [15:0]       result_value;
  logic                     domain_error;

  typedef struct {
    logic signed [15:0] value;
    logic               err;
  } act_result_t;

  // One row of the directed table. Where known is set, the expected result
  // is written into the row; otherwise the predictor supplies it.
  typedef struct {
    logic [2:0]         fsel;
    nau_pkg::kind_t     op;
    logic signed [15:0] x;
    bit                 known;
    logic signed [15:0] value;
    logic               err;
  } directed_row_t;

  act_result_t pending_results[$];
  logic [2:0]  active_fsel;
  int          mismatch_count;
  int          cycle_count;

  neural_activation_unit_top dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .operand_value (operand_value),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .done          (done),
    .result_value  (result_value),
    .domain_error  (domain_error)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // e^-t with t and the result in Q30, by range reduction on ln 2 and a
  // 13-term alternating series.
  function automatic longint unsigned exp_neg(input longint unsigned t);
    longint unsigned k;
    longint unsigned r;
    longint unsigned term;
    longint          sum;
    k = t / LN2_Q;
    if (k >= 63) return 0;
    r = t - k * LN2_Q;
    term = ONE_Q30;
    sum = longint'(ONE_Q30);
    for (longint unsigned n = 1; n <= 13; n++) begin
      term = (term * r) / (n << 30);
      if (n[0]) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    return longint'(unsigned'(sum)) >> k;
  endfunction

  // Natural log of a positive integer, Q30 result, via the atanh series.
  function automatic longint natural_log(input longint unsigned u);
    int unsigned     e;
    longint unsigned m, s, s2, pw;
    longint          sum;
    e = 0;
    sum = 0;
    while (e < 62 && (u >> (e + 1)) != 0) e++;
    m = (e >= 30) ? (u >> (e - 30)) : (u << (30 - e));
    s = ((m - ONE_Q30) << 30) / (m + ONE_Q30);
    s2 = (s * s) >> 30;
    pw = s;
    for (longint unsigned j = 1; j <= 25; j += 2) begin
      sum += longint'(pw / j);
      pw = (pw * s2) >> 30;
    end
    return longint'(e) * longint'(LN2_Q) + 2 * sum;
  endfunction

  function automatic longint round_away(input longint v, input int unsigned sh);
    longint unsigned m;
    m = (v < 0) ? longint'(unsigned'(-v)) : longint'(unsigned'(v));
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  // Q3.12 product, rounded half away from zero.
  function automatic longint fx_product(input longint p, input longint q);
    longint unsigned mp, mq, r;
    mp = (p < 0) ? -p : p;
    mq = (q < 0) ? -q : q;
    r = (mp * mq + 64'd2048) >> 12;
    return ((p < 0) != (q < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic act_result_t compute_activation(input logic [2:0] fsel_in,
                                                     input logic [1:0] op,
                                                     input logic signed [15:0] x);
    act_result_t     res;
    logic [2:0]      fsel;
    longint          v, r, d;
    longint unsigned mag, m30, e, q;
    logic            err;
    fsel = (fsel_in > nau_pkg::FS_RETANH) ? nau_pkg::FS_LINEAR : fsel_in;
    v = x;
    mag = (v < 0) ? -v : v;
    err = 1'b0;
    r = 0;
    case (op)
      nau_pkg::KIND_ACT: begin
        m30 = mag << nau_pkg::SH;
        if (fsel == nau_pkg::FS_TANH || fsel == nau_pkg::FS_RETANH) begin
          if (fsel == nau_pkg::FS_RETANH && v <= 0) r = 0;
          else begin
            if (m30 > (64'd16 << 30)) m30 = 64'd16 << 30;
            e = exp_neg(m30 * 2);
            q = ((ONE_Q30 - e) << 30) / (ONE_Q30 + e);
            r = round_away(longint'(q), nau_pkg::SH);
            if (v < 0) r = -r;
          end
        end else if (fsel == nau_pkg::FS_RELU) begin
          r = (v > 0) ? v : 0;
        end else if (fsel == nau_pkg::FS_SIGMOID) begin
          if (m30 > (64'd32 << 30)) m30 = 64'd32 << 30;
          e = exp_neg(m30);
          q = (v < 0) ? (e << 30) / (ONE_Q30 + e) : (64'd1 << 60) / (ONE_Q30 + e);
          r = round_away(longint'(q), nau_pkg::SH);
        end else begin
          r = v;
        end
      end
      nau_pkg::KIND_DERIV: begin
        if (fsel == nau_pkg::FS_TANH || fsel == nau_pkg::FS_RETANH) begin
          if (fsel == nau_pkg::FS_RETANH && v <= 0) r = 0;
          else r = 4096 - fx_product(v, v);
        end else if (fsel == nau_pkg::FS_RELU) begin
          r = (v > 0) ? 4096 : 0;
        end else if (fsel == nau_pkg::FS_SIGMOID) begin
          r = fx_product(v, 4096 - v);
        end else begin
          r = 4096;
        end
      end
      nau_pkg::KIND_INV: begin
        if (fsel == nau_pkg::FS_TANH || fsel == nau_pkg::FS_RETANH) begin
          if (v >= 4096) begin err = 1'b1; r = 64'sd40000; end
          else if (v <= -4096) begin err = 1'b1; r = -64'sd40000; end
          else begin
            d = natural_log(4096 + v) - natural_log(4096 - v);
            r = round_away(d, nau_pkg::SH + 1);
          end
        end else if (fsel == nau_pkg::FS_SIGMOID) begin
          if (v <= 0) begin err = 1'b1; r = -64'sd40000; end
          else if (v >= 4096) begin err = 1'b1; r = 64'sd40000; end
          else begin
            d = natural_log(v) - natural_log(4096 - v);
            r = round_away(d, nau_pkg::SH);
          end
        end else begin
          r = v;
        end
      end
      default: begin
        r = 0;
        err = 1'b1;
      end
    endcase
    if (r > 32767) begin r = 32767; err = 1'b1; end
    if (r < -32768) begin r = -32768; err = 1'b1; end
    res.value = r[15:0];
    res.err = err;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Present one item and hold it until the block takes it. The expectation
  // is queued on the accepting edge. Start is left high so a burst can run
  // back to back; the caller lowers it for a gap.
  task automatic send_item(input logic [1:0] op, input logic signed [15:0] x,
                           input bit known, input act_result_t typed);
    act_result_t predicted;
    start <= 1'b1;
    kind <= op;
    operand_value <= x;
    do @(posedge clk); while (busy);
    predicted = known ? typed : compute_activation(active_fsel, op, x);
    pending_results.push_back(predicted);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Wait until every queued result has arrived, then write the select.
  // Every item gives a result, so an empty queue means an empty pipeline.
  task automatic write_select(input logic [2:0] fsel);
    idle_cycles(1);
    while (pending_results.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= fsel;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    active_fsel = fsel;
  endtask

  // Results are compared on the edge that ends their one-cycle window.
  always @(posedge clk) begin
    act_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", result_value));
      end else begin
        want = pending_results.pop_front();
        if (result_value !== want.value)
          report_mismatch($sformatf("result_value %0d, expected %0d",
                                    result_value, want.value));
        if (domain_error !== want.err)
          report_mismatch($sformatf("domain_error %b, expected %b (value %0d)",
                                    domain_error, want.err, want.value));
      end
    end
  end

  // Watchdog: a hung handshake or lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    directed_row_t rows[$];
    directed_row_t row;
    act_result_t   typed;
    logic [2:0]    phase_sel[$];
    int            burst_left;
    int            per_phase;
    int            sent;
    logic [1:0]    op;
    logic signed [15:0] x;

    rst = 1'b1;
    start = 1'b0;
    kind = nau_pkg::KIND_ACT;
    operand_value = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = nau_pkg::FS_TANH;
    active_fsel = nau_pkg::FS_TANH;
    mismatch_count = 0;
    cycle_count = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The tanh rows run on the reset value of the select.
    rows = '{
      '{nau_pkg::FS_TANH,    nau_pkg::KIND_ACT,   16'sd0,    0, 16'sd0,  1'b0},
      '{nau_pkg::FS_TANH,    nau_pkg::KIND_ACT,   POS_MAX,   0, 16'sd0,  1'b0},
      '{nau_pkg::FS_TANH,    nau_pkg::KIND_ACT,   NEG_MAX,   0, 16'sd0,  1'b0},
      '{nau_pkg::FS_TANH,    nau_pkg::KIND_DERIV, NEG_MAX,   1, NEG_MAX, 1'b1},
      '{nau_pkg::FS_TANH,    nau_pkg::KIND_INV,   ONE_FX,    1, POS_MAX, 1'b1},
      '{nau_pkg::FS_TANH,    nau_pkg::KIND_INV,   -ONE_FX,   1, NEG_MAX, 1'b1},
      '{nau_pkg::FS_TANH,    nau_pkg::KIND_INV,   16'sd4095, 0, 16'sd0,  1'b0},
      '{nau_pkg::FS_TANH,    nau_pkg::KIND_BAD,   POS_MAX,   1, 16'sd0,  1'b1},
      '{nau_pkg::FS_RELU,    nau_pkg::KIND_ACT,   -16'sd5,   1, 16'sd0,  1'b0},
      '{nau_pkg::FS_RELU,    nau_pkg::KIND_ACT,   POS_MAX,   1, POS_MAX, 1'b0},
      '{nau_pkg::FS_RELU,    nau_pkg::KIND_DERIV, 16'sd1,    1, ONE_FX,  1'b0},
      '{nau_pkg::FS_RELU,    nau_pkg::KIND_DERIV, 16'sd0,    1, 16'sd0,  1'b0},
      '{nau_pkg::FS_RELU,    nau_pkg::KIND_INV,   NEG_MAX,   1, NEG_MAX, 1'b0},
      '{nau_pkg::FS_SIGMOID, nau_pkg::KIND_ACT,   NEG_MAX,   0, 16'sd0,  1'b0},
      '{nau_pkg::FS_SIGMOID, nau_pkg::KIND_ACT,   POS_MAX,   0, 16'sd0,  1'b0},
      '{nau_pkg::FS_SIGMOID, nau_pkg::KIND_DERIV, POS_MAX,   0, 16'sd0,  1'b0},
      '{nau_pkg::FS_SIGMOID, nau_pkg::KIND_INV,   16'sd0,    1, NEG_MAX, 1'b1},
      '{nau_pkg::FS_SIGMOID, nau_pkg::KIND_INV,   ONE_FX,    1, POS_MAX, 1'b1},
      '{nau_pkg::FS_SIGMOID, nau_pkg::KIND_INV,   16'sd1,    0, 16'sd0,  1'b0},
      '{nau_pkg::FS_LINEAR,  nau_pkg::KIND_ACT,   NEG_MAX,   1, NEG_MAX, 1'b0},
      '{nau_pkg::FS_LINEAR,  nau_pkg::KIND_DERIV, 16'sd77,   1, ONE_FX,  1'b0},
      '{nau_pkg::FS_RETANH,  nau_pkg::KIND_ACT,   -16'sd1,   1, 16'sd0,  1'b0},
      '{nau_pkg::FS_RETANH,  nau_pkg::KIND_DERIV, -16'sd1,   1, 16'sd0,  1'b0},
      '{nau_pkg::FS_RETANH,  nau_pkg::KIND_ACT,   ONE_FX,    0, 16'sd0,  1'b0},
      '{FS_SPARE_HI,         nau_pkg::KIND_ACT,   16'sd1234, 1, 16'sd1234, 1'b0}
    };
    foreach (rows[i]) begin
      row = rows[i];
      if (row.fsel != active_fsel) write_select(row.fsel);
      typed.value = row.value;
      typed.err = row.err;
      send_item(row.op, row.x, row.known, typed);
      if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 3));
    end

    // Random part: one phase per select, unused codes 5 and 7 and both extremes
    // of the register included, then tanh, sigmoid and retanh once more.
    phase_sel = '{FS_SPARE_HI, nau_pkg::FS_TANH, nau_pkg::FS_SIGMOID,
                  nau_pkg::FS_RETANH, nau_pkg::FS_RELU, nau_pkg::FS_LINEAR,
                  FS_SPARE_LO, nau_pkg::FS_TANH, nau_pkg::FS_SIGMOID,
                  nau_pkg::FS_RETANH};
    per_phase = N_RANDOM / phase_sel.size();
    burst_left = 0;
    foreach (phase_sel[p]) begin
      write_select(phase_sel[p]);
      sent = 0;
      while (sent < per_phase) begin
        // Kind 3 is rare; the domain of the inverses and of the activated
        // values sits within one unit, so most operands are kept near it.
        op = ($urandom_range(0, 29) == 0) ? nau_pkg::KIND_BAD
                                           : 2'($urandom_range(0, 2));
        case ($urandom_range(0, 3))
          0: x = 16'($urandom_range(0, 65535));
          1: x = 16'sd4096 - 16'($urandom_range(0, 3));
          default: x = 16'($urandom_range(0, 9000)) - 16'sd4500;
        endcase
        send_item(op, x, 1'b0, typed);
        sent++;
        if (burst_left == 0) begin
          // Gaps of random length; a fifth of the bursts run with none.
          if ($urandom_range(0, 4) != 0) idle_cycles($urandom_range(1, 8));
          burst_left = $urandom_range(1, 24);
        end else begin
          burst_left--;
        end
      end
    end

    idle_cycles(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/nau_pkg.sv
rtl/nau_div.sv
rtl/nau_exp.sv
rtl/nau_ln.sv
rtl/neural_activation_unit_top.sv
bench/tb_neural_activation_unit_top.sv
